// ===== hw/rtl/ncws_pkg.sv =====
`timescale 1ns / 1ps

package ncws_pkg;

    localparam int DEPTH_BITS  = 16;
    localparam int LENGTH_BITS = 16;
    localparam int LEN_EXT     = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    localparam int CHAR_W     = 21;
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 3;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WS    = 2'd1;
    localparam logic [1:0] KIND_CMT   = 2'd2;
    localparam logic [1:0] KIND_UNTRM = 2'd3;

    localparam logic [CHAR_W-1:0] CH_SPACE = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] CH_TAB   = CHAR_W'(9);
    localparam logic [CHAR_W-1:0] CH_SLASH = CHAR_W'(47);
    localparam logic [CHAR_W-1:0] CH_STAR  = CHAR_W'(42);

    typedef struct packed {
        logic              start_req;
        logic              allow_whitespace;
        logic              allow_comment;
        logic [CHAR_W-1:0] char_code;
        logic              at_end;
    } t_item;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [15:0] token_length;
        logic        ending_consumed;
    } t_result;

    function automatic logic [15:0] clamp_len(input logic [LENGTH_BITS-1:0] len);
        logic [LEN_EXT-1:0] v;
        v = LEN_EXT'(len);
        if (v > LEN_EXT'(17'h0FFFF)) begin
            return 16'hFFFF;
        end
        return v[15:0];
    endfunction

endpackage

// ===== hw/rtl/ncws_in_reg.sv =====
`timescale 1ns / 1ps

module ncws_in_reg
    import ncws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_DATA_W-1:0] i_s_axis_tdata,
    input  logic [IN_USER_W-1:0] i_s_axis_tuser,
    input  logic                 i_s_axis_tlast,
    output logic                 o_valid,
    output t_item                o_item,
    input  logic                 i_take
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_s_axis_tready = !r_valid || i_take;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.start_req        <= i_s_axis_tuser[0];
            r_item.allow_whitespace <= i_s_axis_tuser[1];
            r_item.allow_comment    <= i_s_axis_tuser[2];
            r_item.char_code        <= i_s_axis_tdata[CHAR_W-1:0];
            r_item.at_end           <= i_s_axis_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/ncws_core.sv =====
`timescale 1ns / 1ps

module ncws_core
    import ncws_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_take,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_WS    = 3'd1;
    localparam logic [2:0] MODE_OPEN  = 3'd2;
    localparam logic [2:0] MODE_BODY  = 3'd3;
    localparam logic [2:0] MODE_STAR  = 3'd4;
    localparam logic [2:0] MODE_SLASH = 3'd5;

    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LEN_MAX   = {LENGTH_BITS{1'b1}};

    logic [2:0]             r_mode, n_mode;
    logic [DEPTH_BITS-1:0]  r_depth, n_depth;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_res_valid;
    t_result                r_res;

    logic                   emit;
    logic [1:0]             emit_kind;
    logic                   emit_cons;
    logic [LENGTH_BITS-1:0] emit_len;
    logic [LENGTH_BITS-1:0] len_inc;
    logic [DEPTH_BITS-1:0]  depth_dec;
    logic                   blank;
    logic [CHAR_W-1:0]      c;

    assign o_take  = i_valid && (!r_res_valid || i_res_ready);
    assign c       = i_item.char_code;
    assign blank   = (c == CH_SPACE) || (c == CH_TAB);
    assign len_inc = (r_len == LEN_MAX) ? r_len : r_len + LENGTH_BITS'(1);
    assign depth_dec = r_depth - DEPTH_BITS'(1);

    always_comb begin
        n_mode    = r_mode;
        n_depth   = r_depth;
        n_len     = r_len;
        emit      = 1'b0;
        emit_kind = KIND_NONE;
        emit_cons = 1'b0;
        emit_len  = r_len;
        if (i_item.start_req) begin
            n_mode  = MODE_IDLE;
            n_depth = '0;
            n_len   = '0;
            if (i_item.at_end) begin
                emit = 1'b1;
            end else if (i_item.allow_whitespace && blank) begin
                n_mode = MODE_WS;
                n_len  = LENGTH_BITS'(1);
            end else if (i_item.allow_comment && (c == CH_SLASH)) begin
                n_mode = MODE_OPEN;
                n_len  = LENGTH_BITS'(1);
            end else begin
                emit = 1'b1;
            end
        end else begin
            case (r_mode)
                MODE_WS: begin
                    if (i_item.at_end || !blank) begin
                        emit      = 1'b1;
                        emit_kind = KIND_WS;
                    end else begin
                        n_len = len_inc;
                    end
                end
                MODE_OPEN: begin
                    if (i_item.at_end || (c != CH_STAR)) begin
                        emit = 1'b1;
                    end else begin
                        n_len   = len_inc;
                        n_depth = DEPTH_BITS'(1);
                        n_mode  = MODE_BODY;
                    end
                end
                MODE_BODY, MODE_STAR, MODE_SLASH: begin
                    if (i_item.at_end) begin
                        emit      = 1'b1;
                        emit_kind = KIND_UNTRM;
                    end else if ((r_mode == MODE_STAR) && (c == CH_SLASH)) begin
                        n_len   = len_inc;
                        n_depth = depth_dec;
                        n_mode  = MODE_BODY;
                        if (depth_dec == '0) begin
                            emit      = 1'b1;
                            emit_kind = KIND_CMT;
                            emit_cons = 1'b1;
                            emit_len  = len_inc;
                        end
                    end else if ((r_mode == MODE_SLASH) && (c == CH_STAR)) begin
                        n_len   = len_inc;
                        n_depth = (r_depth == DEPTH_MAX) ? r_depth
                                                         : r_depth + DEPTH_BITS'(1);
                        n_mode  = MODE_BODY;
                    end else begin
                        n_len = len_inc;
                        if (c == CH_STAR) begin
                            n_mode = MODE_STAR;
                        end else if (c == CH_SLASH) begin
                            n_mode = MODE_SLASH;
                        end else begin
                            n_mode = MODE_BODY;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end
        if (emit) begin
            n_mode  = MODE_IDLE;
            n_depth = '0;
            n_len   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_depth     <= '0;
            r_len       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_mode  <= n_mode;
                r_depth <= n_depth;
                r_len   <= n_len;
            end
            if (o_take && emit) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_res.token_kind      <= emit_kind;
            r_res.token_length    <= (emit_kind == KIND_NONE) ? 16'd0 : clamp_len(emit_len);
            r_res.ending_consumed <= emit_cons;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== hw/rtl/nested_comment_whitespace_scanner.sv =====
`timescale 1ns / 1ps
// Channel   Direction  tdata                     tuser                             tlast
// s_axis    in         char_code[20:0], pad      start_req, allow_ws, allow_comment at_end
// m_axis    out        token_length[15:0]        token_kind[1:0], ending_consumed  none
//
// One character per clock is sustained while no result is held on m_axis. The
// character that ends the scan passes the input register, then the result register.
// The next scan state is combinational, so the state loop sets the rate.
// Reset is synchronous and active low; it returns the scanner to idle with no result.
// A stall on m_axis holds the result and fills the input register, then drops s_axis tready.

module nested_comment_whitespace_scanner
    import ncws_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // char_code[20:0], zero pad [23:21]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // start_req[0], allow_whitespace[1], allow_comment[2]
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // token_length[15:0]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // token_kind[1:0], ending_consumed[2]
    output logic [OUT_USER_W-1:0] o_m_axis_tuser
);

    logic    item_valid;
    t_item   item;
    logic    take;
    t_result res;

    ncws_in_reg u_in_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_valid         (item_valid),
        .o_item          (item),
        .i_take          (take)
    );

    ncws_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (item_valid),
        .i_item      (item),
        .o_take      (take),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = res.token_length;
    assign o_m_axis_tuser = {res.ending_consumed, res.token_kind};

endmodule
